// File: sv/wavt_pkg.sv
// Shared types and constants for the wheel angle / velocity tracker.
// No dependencies; used by every design module of the block.
package wavt_pkg;

	// divider geometry: dividend is the velocity numerator magnitude (< 2^52)
	localparam int DIV_W   = 53;
	localparam int DEN_W   = 33;
	localparam int CNT_W   = 6;
	localparam int ANG_NUM_W = 36;          // (raw-min)*range*256
	localparam logic [CNT_W-1:0] ANG_STEPS = CNT_W'(ANG_NUM_W);
	localparam logic [CNT_W-1:0] VEL_STEPS = CNT_W'(DIV_W);

	localparam logic [11:0] DEF_RANGE_DEG = 12'd1080;
	localparam logic signed [20:0] US_PER_S = 21'sd1000000;
	localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;

	// config register indexes
	localparam logic [1:0] REG_AXIS_MIN  = 2'd0;
	localparam logic [1:0] REG_AXIS_MAX  = 2'd1;
	localparam logic [1:0] REG_RANGE_DEG = 2'd2;
	localparam logic [1:0] REG_TAU_US    = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // capture input transfer
		logic ang_mul;    // clamp and multiply by range
		logic div_start;  // start shared divider
		logic div_vel;    // divider operand select: 1 = velocity
		logic ang_fin;    // offset quotient into signed angle
		logic vel_mul;    // v*tau and delta*1e6
		logic vel_sum;    // numerator sum
		logic vel_fin;    // saturate and store velocity
		logic commit;     // update history, load output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic upd_vel;    // previous sample seen and dt nonzero
	} sts_t;

endpackage

// File: sv/wavt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, unsigned.
// Depends on wavt_pkg for widths.
module wavt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wavt_pkg::DIV_W-1:0]    dividend,
	input  logic [wavt_pkg::DEN_W-1:0]    divisor,
	input  logic [wavt_pkg::CNT_W-1:0]    nbits,
	output logic                          done,
	output logic [wavt_pkg::DIV_W-1:0]    quotient
);

	logic [wavt_pkg::DIV_W-1:0] dvd_q;
	logic [wavt_pkg::DIV_W-1:0] quo_q;
	logic [wavt_pkg::DEN_W-1:0] rem_q;
	logic [wavt_pkg::DEN_W-1:0] den_q;
	logic [wavt_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [wavt_pkg::DEN_W:0]   trial;
	logic [wavt_pkg::DEN_W:0]   diff;
	logic                       fits;

	assign trial = {rem_q, dvd_q[wavt_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - wavt_pkg::CNT_W'(1);
				if (cnt_q == wavt_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[wavt_pkg::DIV_W-2:0], 1'b0};
			rem_q <= fits ? diff[wavt_pkg::DEN_W-1:0] : trial[wavt_pkg::DEN_W-1:0];
			quo_q <= {quo_q[wavt_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/wavt_dp.sv
// Datapath: config registers, tracking state, multipliers and the shared divider.
// Depends on wavt_pkg and wavt_div.
module wavt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  wavt_pkg::cmd_t      cmd,
	output wavt_pkg::sts_t      sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [19:0]         cfg_wdata,
	input  logic [15:0]         raw_position,
	input  logic [31:0]         sample_time_us,
	output logic [19:0]         angle_q8,
	output logic [31:0]         velocity_q8
);

	// config
	logic [15:0] amin_q, amax_q;
	logic [11:0] range_q;
	logic [19:0] tau_q;

	// history
	logic signed [19:0] last_angle_q;
	logic signed [31:0] vel_q;
	logic [31:0]        last_time_q;
	logic               have_prev_q;

	// working
	logic [15:0]        raw_q;
	logic [31:0]        time_q;
	logic [27:0]        ang_prod_q;
	logic [11:0]        rng_eff_q;
	logic               span_bad_q;
	logic [15:0]        span_q;
	logic signed [19:0] angle_q;
	logic signed [52:0] mv_q;
	logic signed [41:0] md_q;
	logic signed [52:0] num_q;
	logic               neg_q;
	logic [19:0]        out_angle_q;
	logic [31:0]        out_vel_q;

	logic [11:0]               rng_eff;
	logic [15:0]               clamped;
	logic [15:0]               offset;
	logic signed [20:0]        delta;
	logic [20:0]               ang_diff;
	logic [52:0]               mag;
	logic [wavt_pkg::DEN_W-1:0] den;
	logic [wavt_pkg::DIV_W-1:0] div_dvd;
	logic [wavt_pkg::DEN_W-1:0] div_den;
	logic [wavt_pkg::CNT_W-1:0] div_n;
	logic                       div_done;
	logic [wavt_pkg::DIV_W-1:0] quo;
	logic [31:0]                sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amin_q  <= 16'd0;
			amax_q  <= 16'hFFFF;
			range_q <= wavt_pkg::DEF_RANGE_DEG;
			tau_q   <= 20'd20000;
		end else if (cfg_we) begin
			case (cfg_idx)
				wavt_pkg::REG_AXIS_MIN:  amin_q  <= cfg_wdata[15:0];
				wavt_pkg::REG_AXIS_MAX:  amax_q  <= cfg_wdata[15:0];
				wavt_pkg::REG_RANGE_DEG: range_q <= cfg_wdata[11:0];
				wavt_pkg::REG_TAU_US:    tau_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// angle front end
	assign rng_eff = (range_q == 12'd0) ? wavt_pkg::DEF_RANGE_DEG : range_q;
	always_comb begin
		clamped = raw_q;
		if (raw_q < amin_q)
			clamped = amin_q;
		if (raw_q > amax_q)
			clamped = amax_q;
	end
	assign offset = clamped - amin_q;

	assign ang_diff = {1'b0, quo[19:0]} - {2'b00, rng_eff_q, 7'd0};
	assign delta    = 21'(angle_q) - 21'(last_angle_q);

	// velocity divider operands
	assign mag = num_q[52] ? 53'(-num_q) : 53'(num_q);
	assign den = {1'b0, time_q - last_time_q} + {13'd0, tau_q};

	assign div_dvd = cmd.div_vel ? mag : {ang_prod_q, 8'd0, 17'd0};
	assign div_den = cmd.div_vel ? den : {17'd0, span_q};
	assign div_n   = cmd.div_vel ? wavt_pkg::VEL_STEPS : wavt_pkg::ANG_STEPS;

	wavt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.nbits    (div_n),
		.done     (div_done),
		.quotient (quo)
	);

	assign sat = (|quo[52:31]) ? wavt_pkg::VEL_MAX : {1'b0, quo[30:0]};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q  <= raw_position;
			time_q <= sample_time_us;
		end
		if (cmd.ang_mul) begin
			ang_prod_q <= 28'(offset) * 28'(rng_eff);
			rng_eff_q  <= rng_eff;
			span_q     <= amax_q - amin_q;
			span_bad_q <= (amax_q <= amin_q);
		end
		if (cmd.ang_fin)
			angle_q <= span_bad_q ? 20'sd0 : $signed(ang_diff[19:0]);
		if (cmd.vel_mul) begin
			mv_q <= 53'(vel_q) * 53'($signed({1'b0, tau_q}));
			md_q <= 42'(delta) * 42'(wavt_pkg::US_PER_S);
		end
		if (cmd.vel_sum)
			num_q <= mv_q + 53'(md_q);
		if (cmd.div_start)
			neg_q <= num_q[52];
		if (cmd.commit) begin
			out_angle_q <= angle_q;
			out_vel_q   <= vel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			vel_q        <= '0;
			last_time_q  <= '0;
			have_prev_q  <= 1'b0;
		end else begin
			if (cmd.vel_fin)
				vel_q <= neg_q ? $signed(-sat) : $signed(sat);
			if (cmd.commit) begin
				last_angle_q <= angle_q;
				last_time_q  <= time_q;
				have_prev_q  <= 1'b1;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.upd_vel  = have_prev_q && (time_q != last_time_q);

	assign angle_q8    = out_angle_q;
	assign velocity_q8 = out_vel_q;

endmodule

// File: sv/wavt_ctrl.sv
// Sequencing FSM: steps one sample through the angle phase and, when velocity updates, the velocity phase.
// Depends on wavt_pkg for the command/status structs.
module wavt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output wavt_pkg::cmd_t cmd,
	input  wavt_pkg::sts_t sts
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_ANG_MUL   = 11'b000_0000_0010,
		ST_ANG_START = 11'b000_0000_0100,
		ST_ANG_WAIT  = 11'b000_0000_1000,
		ST_ANG_FIN   = 11'b000_0001_0000,
		ST_VEL_MUL   = 11'b000_0010_0000,
		ST_VEL_SUM   = 11'b000_0100_0000,
		ST_VEL_START = 11'b000_1000_0000,
		ST_VEL_WAIT  = 11'b001_0000_0000,
		ST_VEL_FIN   = 11'b010_0000_0000,
		ST_DONE      = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free = !valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ANG_MUL;
				end
			end
			ST_ANG_MUL: begin
				cmd.ang_mul = 1'b1;
				state_d     = ST_ANG_START;
			end
			ST_ANG_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_ANG_WAIT;
			end
			ST_ANG_WAIT: begin
				if (sts.div_done)
					state_d = ST_ANG_FIN;
			end
			ST_ANG_FIN: begin
				cmd.ang_fin = 1'b1;
				state_d     = sts.upd_vel ? ST_VEL_MUL : ST_DONE;
			end
			ST_VEL_MUL: begin
				cmd.vel_mul = 1'b1;
				state_d     = ST_VEL_SUM;
			end
			ST_VEL_SUM: begin
				cmd.vel_sum = 1'b1;
				state_d     = ST_VEL_START;
			end
			ST_VEL_START: begin
				cmd.div_start = 1'b1;
				cmd.div_vel   = 1'b1;
				state_d       = ST_VEL_WAIT;
			end
			ST_VEL_WAIT: begin
				cmd.div_vel = 1'b1;
				if (sts.div_done)
					state_d = ST_VEL_FIN;
			end
			ST_VEL_FIN: begin
				cmd.div_vel = 1'b1;
				cmd.vel_fin = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = valid_q;

endmodule

// File: sv/wheel_angle_velocity_tracker_top.sv
// Wheel angle and smoothed velocity tracker, top level.
// A result follows the input transfer after two serial divisions (36-bit and 53-bit quotients)
// when velocity updates, and after the angle division alone when it does not (first sample, dt zero).
// One sample in flight at a time; the shared one-bit-per-cycle divider sets the pace.
// Output register holds one result, so the next sample is taken while it waits.
// Reset (arst_n low, async): config back to 0/65535/1080/20000, history cleared.
module wheel_angle_velocity_tracker_top (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] raw_position, [47:16] sample_time_us
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [19:0] angle_q8, [51:20] velocity_q8, [55:52] zero
	// config writes, always accepted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	wavt_pkg::cmd_t cmd;
	wavt_pkg::sts_t sts;
	logic [19:0]    angle_q8;
	logic [31:0]    velocity_q8;

	// The user must write config only while idle; the block does not enforce it, so no interlock with the sequencer.
	assign cfg_ready = 1'b1;

	wavt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath captures s_tdata on load_in, i.e. on the input transfer.
	wavt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid),
		.cfg_idx        (cfg_index),
		.cfg_wdata      (cfg_data),
		.raw_position   (s_tdata[15:0]),
		.sample_time_us (s_tdata[47:16]),
		.angle_q8       (angle_q8),
		.velocity_q8    (velocity_q8)
	);

	assign m_tdata = {4'd0, velocity_q8, angle_q8};

endmodule

// File: sv/wavt_checker.sv
// Port-level checks for the tracker, bound onto the top level.
// Depends only on the top level's ports.
module wavt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one sample in flight: input closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open right after transfer");

	// no result can appear the cycle after a sample transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

	// velocity saturation is symmetric
	a_vel_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[51:20] != 32'h8000_0000)
		else $error("velocity below negative limit");

	// angle stays no lower than minus half the widest rotation
	a_ang_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[19:0]) >= -20'sd524160)
		else $error("angle out of range");

endmodule

bind wheel_angle_velocity_tracker_top wavt_checker u_wavt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
